/* rtl/core/qalu_pkg.sv */
`timescale 1ns / 1ps

package qalu_pkg;

    localparam int DW = 48;
    localparam int FW = 24;

    localparam int LW = DW / 2;
    localparam int UW = DW - LW;
    localparam int AW = 2 * DW + 2;

    localparam int SQN  = AW / 2;
    localparam int RTW  = SQN;
    localparam int SRW  = RTW + 2;
    localparam int DENW = RTW + 1;
    localparam int RMW  = DENW;
    localparam int QW   = FW + 1;
    localparam int NUMW = DW + QW + 1;

    localparam int H_LAT    = 4;
    localparam int NORM_LAT = SQN + QW + 2;

    localparam logic [DW-1:0] CMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] CMIN = {1'b1, {(DW-1){1'b0}}};

    // bit k*4+i: term a[i]*b[k^i] of component k is subtracted
    localparam logic [15:0] NEG_TAB   = {4'b0100, 4'b0010, 4'b1000, 4'b1110};
    localparam logic [15:0] CONJ_MASK = 16'h7BDE;

    typedef logic [3:0][DW-1:0] quat_t;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_ROT  = 3'd1,
        OP_DER  = 3'd2,
        OP_NORM = 3'd3,
        OP_CONJ = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef enum logic {
        SH_FW  = 1'b0,
        SH_FW1 = 1'b1
    } shift_t;

    typedef struct packed {
        logic [15:0] neg;
        shift_t      shift;
    } hctl_t;

endpackage

/* rtl/core/qalu_hprod.sv */
`timescale 1ns / 1ps

module qalu_hprod (
    input  logic                  aclk,
    input  logic                  en,
    input  qalu_pkg::quat_t       a_in,
    input  qalu_pkg::quat_t       b_in,
    input  qalu_pkg::hctl_t       ctl,
    output qalu_pkg::quat_t       r_out,
    output logic                  sat_out,
    output logic [qalu_pkg::AW-1:0] sum0_out
);
    import qalu_pkg::*;

    logic signed [2*UW-1:0]  hh_reg [16];
    logic signed [UW+LW:0]   hl_reg [16];
    logic signed [UW+LW:0]   lh_reg [16];
    logic        [2*LW-1:0]  ll_reg [16];
    logic signed [2*UW-1:0]  hh_next [16];
    logic signed [UW+LW:0]   hl_next [16];
    logic signed [UW+LW:0]   lh_next [16];
    logic        [2*LW-1:0]  ll_next [16];
    logic [15:0]             neg1_reg;
    shift_t                  sh1_reg, sh2_reg, sh3_reg;
    logic signed [AW-1:0]    p_reg [16];
    logic signed [AW-1:0]    p_next [16];
    logic signed [AW-1:0]    acc_reg [4];
    logic signed [AW-1:0]    acc_next [4];
    quat_t                   r_reg, r_next;
    logic                    sat_reg, sat_next;
    logic [AW-1:0]           sum0_reg;

    // stage 1: partial products
    always_comb begin
        logic [1:0]    ki, ii, ji;
        logic [3:0]    n;
        logic [DW-1:0] av, bv;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 4; i++) begin
                ki = 2'(k);
                ii = 2'(i);
                ji = ki ^ ii;
                n  = {ki, ii};
                av = a_in[ii];
                bv = b_in[ji];
                hh_next[n] = $signed(av[DW-1:LW]) * $signed(bv[DW-1:LW]);
                hl_next[n] = $signed(av[DW-1:LW]) * $signed({1'b0, bv[LW-1:0]});
                lh_next[n] = $signed({1'b0, av[LW-1:0]}) * $signed(bv[DW-1:LW]);
                ll_next[n] = av[LW-1:0] * bv[LW-1:0];
            end
        end
    end

    // stage 2: full products with sign
    always_comb begin
        logic signed [AW-1:0] t;
        for (int n = 0; n < 16; n++) begin
            t = (AW'(hh_reg[n]) << (2 * LW)) + (AW'(hl_reg[n]) << LW)
              + (AW'(lh_reg[n]) << LW) + $signed(AW'(ll_reg[n]));
            p_next[n] = neg1_reg[n] ? -t : t;
        end
    end

    // stage 3: component sums
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc_next[k] = p_reg[4*k] + p_reg[4*k+1] + p_reg[4*k+2] + p_reg[4*k+3];
        end
    end

    // stage 4: round half up, saturate
    always_comb begin
        logic signed [AW-1:0] sm, v;
        logic [AW-DW:0]       hi;
        sat_next = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (sh3_reg == SH_FW) begin
                sm = acc_reg[k] + (AW'(1) << (FW - 1));
                v  = sm >>> FW;
            end else begin
                sm = acc_reg[k] + (AW'(1) << FW);
                v  = sm >>> (FW + 1);
            end
            hi = v[AW-1:DW-1];
            if ((&hi) || !(|hi)) begin
                r_next[k] = v[DW-1:0];
            end else begin
                r_next[k] = v[AW-1] ? CMIN : CMAX;
                sat_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < 16; n++) begin
                hh_reg[n] <= hh_next[n];
                hl_reg[n] <= hl_next[n];
                lh_reg[n] <= lh_next[n];
                ll_reg[n] <= ll_next[n];
                p_reg[n]  <= p_next[n];
            end
            for (int k = 0; k < 4; k++) begin
                acc_reg[k] <= acc_next[k];
            end
            neg1_reg <= ctl.neg;
            sh1_reg  <= ctl.shift;
            sh2_reg  <= sh1_reg;
            sh3_reg  <= sh2_reg;
            r_reg    <= r_next;
            sat_reg  <= sat_next;
            sum0_reg <= acc_reg[0];
        end
    end

    assign r_out    = r_reg;
    assign sat_out  = sat_reg;
    assign sum0_out = sum0_reg;

endmodule

/* rtl/core/qalu_norm.sv */
`timescale 1ns / 1ps

module qalu_norm (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [qalu_pkg::AW-1:0] sum_in,
    input  qalu_pkg::quat_t         a_in,
    output qalu_pkg::quat_t         q_out,
    output logic                    zero_out
);
    import qalu_pkg::*;

    // square root, one result bit per stage
    logic [SRW-1:0]     srem_reg  [SQN];
    logic [RTW-1:0]     sroot_reg [SQN];
    logic [AW-1:0]      sbits_reg [SQN];
    logic               sz_reg    [SQN];
    logic [3:0]         ssgn_reg  [SQN];
    quat_t              smag_reg  [SQN];
    logic [SRW-1:0]     srem_next  [SQN];
    logic [RTW-1:0]     sroot_next [SQN];
    logic [AW-1:0]      sbits_next [SQN];
    logic               sz_next    [SQN];
    logic [3:0]         ssgn_next  [SQN];
    quat_t              smag_next  [SQN];

    logic [DENW-1:0]    pden_reg;
    logic [NUMW-1:0]    pnum_reg [4];
    logic [3:0]         psgn_reg;
    logic               pz_reg;

    // restoring division, one quotient bit per stage
    logic [RMW-1:0]     drem_reg [QW][4];
    logic [QW-1:0]      dlo_reg  [QW][4];
    logic [QW-1:0]      dq_reg   [QW][4];
    logic [DENW-1:0]    dden_reg [QW];
    logic [3:0]         dsgn_reg [QW];
    logic               dz_reg   [QW];
    logic [RMW-1:0]     drem_next [QW][4];
    logic [QW-1:0]      dlo_next  [QW][4];
    logic [QW-1:0]      dq_next   [QW][4];

    quat_t              q_reg;
    logic               zero_reg;

    always_comb begin
        logic [SRW-1:0] rem_p, cur, trial;
        logic [RTW-1:0] root_p;
        logic [AW-1:0]  bits_p;
        for (int s = 0; s < SQN; s++) begin
            if (s == 0) begin
                rem_p  = '0;
                root_p = '0;
                bits_p = sum_in;
                sz_next[s] = (sum_in == '0);
                for (int c = 0; c < 4; c++) begin
                    ssgn_next[s][c] = a_in[c][DW-1];
                    smag_next[s][c] = a_in[c][DW-1] ? -a_in[c] : a_in[c];
                end
            end else begin
                rem_p  = srem_reg[s-1];
                root_p = sroot_reg[s-1];
                bits_p = sbits_reg[s-1];
                sz_next[s]   = sz_reg[s-1];
                ssgn_next[s] = ssgn_reg[s-1];
                smag_next[s] = smag_reg[s-1];
            end
            cur   = {rem_p[SRW-3:0], bits_p[AW-1:AW-2]};
            trial = {root_p, 2'b01};
            if (cur >= trial) begin
                srem_next[s]  = cur - trial;
                sroot_next[s] = {root_p[RTW-2:0], 1'b1};
            end else begin
                srem_next[s]  = cur;
                sroot_next[s] = {root_p[RTW-2:0], 1'b0};
            end
            sbits_next[s] = bits_p << 2;
        end
    end

    always_comb begin
        logic [RMW-1:0]  rem_p;
        logic [QW-1:0]   lo_p, q_p;
        logic [DENW-1:0] den;
        logic [RMW:0]    cur;
        for (int d = 0; d < QW; d++) begin
            for (int c = 0; c < 4; c++) begin
                if (d == 0) begin
                    rem_p = RMW'(pnum_reg[c] >> QW);
                    lo_p  = pnum_reg[c][QW-1:0];
                    q_p   = '0;
                    den   = pden_reg;
                end else begin
                    rem_p = drem_reg[d-1][c];
                    lo_p  = dlo_reg[d-1][c];
                    q_p   = dq_reg[d-1][c];
                    den   = dden_reg[d-1];
                end
                cur = {rem_p, lo_p[QW-1]};
                if (cur >= (RMW+1)'(den)) begin
                    drem_next[d][c] = RMW'(cur - (RMW+1)'(den));
                    dq_next[d][c]   = {q_p[QW-2:0], 1'b1};
                end else begin
                    drem_next[d][c] = RMW'(cur);
                    dq_next[d][c]   = {q_p[QW-2:0], 1'b0};
                end
                dlo_next[d][c] = lo_p << 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [RTW-1:0] m;
        logic [DW-1:0]  qv;
        if (en) begin
            for (int s = 0; s < SQN; s++) begin
                srem_reg[s]  <= srem_next[s];
                sroot_reg[s] <= sroot_next[s];
                sbits_reg[s] <= sbits_next[s];
                sz_reg[s]    <= sz_next[s];
                ssgn_reg[s]  <= ssgn_next[s];
                smag_reg[s]  <= smag_next[s];
            end

            m = sroot_reg[SQN-1];
            pden_reg <= {m, 1'b0};
            for (int c = 0; c < 4; c++) begin
                pnum_reg[c] <= (NUMW'(smag_reg[SQN-1][c]) << QW) + NUMW'(m);
            end
            psgn_reg <= ssgn_reg[SQN-1];
            pz_reg   <= sz_reg[SQN-1];

            for (int d = 0; d < QW; d++) begin
                for (int c = 0; c < 4; c++) begin
                    drem_reg[d][c] <= drem_next[d][c];
                    dlo_reg[d][c]  <= dlo_next[d][c];
                    dq_reg[d][c]   <= dq_next[d][c];
                end
                dden_reg[d] <= (d == 0) ? pden_reg : dden_reg[d-1];
                dsgn_reg[d] <= (d == 0) ? psgn_reg : dsgn_reg[d-1];
                dz_reg[d]   <= (d == 0) ? pz_reg : dz_reg[d-1];
            end

            for (int c = 0; c < 4; c++) begin
                qv = DW'(dq_reg[QW-1][c]);
                if (dz_reg[QW-1]) begin
                    q_reg[c] <= '0;
                end else begin
                    q_reg[c] <= dsgn_reg[QW-1][c] ? -qv : qv;
                end
            end
            zero_reg <= dz_reg[QW-1];
        end
    end

    assign q_out    = q_reg;
    assign zero_out = zero_reg;

endmodule

/* rtl/core/quaternion_alu.sv */
`timescale 1ns / 1ps

// Quaternion ALU: multiply, vector rotate, attitude derivative, normalize and
// conjugate on signed Q23.24 operands. Fully pipelined: one word is accepted
// every cycle while the output is not stalled, and every result leaves after
// the same delay whatever the opcode; that delay is set by the normalize path
// (49 square-root stages and 25 divider stages behind a four-stage Hamilton
// product). All ops take the same path, so results come out in order. A result
// held in the output register by a low m_tready freezes the whole pipeline and
// holds s_tready low; there is no state and no setup after reset.
module quaternion_alu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [383:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [2:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // r_w, r_x, r_y, r_z
    output logic [1:0]   m_tuser    // status
);
    import qalu_pkg::*;

    localparam int L3 = NORM_LAT - H_LAT;

    logic    en;
    quat_t   a_in, b_in, b1;
    op_t     op_in;
    hctl_t   ctl1, ctl2;

    logic    v1_reg [H_LAT];
    op_t     op1_reg [H_LAT];
    quat_t   a1_reg [H_LAT];

    quat_t   r1;
    logic    sat1;
    logic [AW-1:0] sum0;

    logic    v2_reg [H_LAT];
    op_t     op2_reg [H_LAT];
    quat_t   a2_reg [H_LAT];
    quat_t   r1_2_reg [H_LAT];
    logic    sat1_2_reg [H_LAT];

    quat_t   r2;
    logic    sat2;
    quat_t   nq;
    logic    nzero;

    quat_t   misc_r;
    status_t misc_st;

    logic    v3_reg [L3];
    op_t     op3_reg [L3];
    quat_t   r3_reg [L3];
    status_t st3_reg [L3];

    logic    m_tvalid_reg;
    quat_t   m_data_reg;
    status_t m_status_reg;
    op_t     out_op_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            a_in[c] = s_tdata[c*DW +: DW];
            b_in[c] = s_tdata[(c+4)*DW +: DW];
        end
        op_in = op_t'(s_tuser);
        b1         = b_in;
        ctl1.neg   = NEG_TAB;
        ctl1.shift = SH_FW;
        unique case (op_in) inside
            OP_ROT: begin
                b1[0] = '0;
            end
            OP_DER: begin
                b1[0]      = '0;
                ctl1.shift = SH_FW1;
            end
            OP_NORM: begin
                b1       = a_in;
                ctl1.neg = '0;
            end
            default: begin
            end
        endcase
        ctl2.neg   = NEG_TAB ^ CONJ_MASK;
        ctl2.shift = SH_FW;
    end

    qalu_hprod u_h1 (
        .aclk    (aclk),
        .en      (en),
        .a_in    (a_in),
        .b_in    (b1),
        .ctl     (ctl1),
        .r_out   (r1),
        .sat_out (sat1),
        .sum0_out(sum0)
    );

    qalu_hprod u_h2 (
        .aclk    (aclk),
        .en      (en),
        .a_in    (r1),
        .b_in    (a1_reg[H_LAT-1]),
        .ctl     (ctl2),
        .r_out   (r2),
        .sat_out (sat2),
        .sum0_out()
    );

    qalu_norm u_norm (
        .aclk    (aclk),
        .en      (en),
        .sum_in  (sum0),
        .a_in    (a1_reg[H_LAT-1]),
        .q_out   (nq),
        .zero_out(nzero)
    );

    always_comb begin
        misc_r  = '0;
        misc_st = ST_OK;
        unique case (op2_reg[H_LAT-1]) inside
            OP_MUL, OP_DER: begin
                misc_r  = r1_2_reg[H_LAT-1];
                misc_st = sat1_2_reg[H_LAT-1] ? ST_SAT : ST_OK;
            end
            OP_ROT: begin
                misc_r    = r2;
                misc_r[0] = '0;
                misc_st   = (sat1_2_reg[H_LAT-1] || sat2) ? ST_SAT : ST_OK;
            end
            OP_CONJ: begin
                misc_r[0] = a2_reg[H_LAT-1][0];
                for (int c = 1; c < 4; c++) begin
                    if (a2_reg[H_LAT-1][c] == CMIN) begin
                        misc_r[c] = CMAX;
                        misc_st   = ST_SAT;
                    end else begin
                        misc_r[c] = -a2_reg[H_LAT-1][c];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < H_LAT; i++) begin
                v1_reg[i] <= 1'b0;
                v2_reg[i] <= 1'b0;
            end
            for (int i = 0; i < L3; i++) begin
                v3_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            for (int i = 0; i < H_LAT; i++) begin
                v1_reg[i] <= (i == 0) ? s_tvalid : v1_reg[i-1];
                v2_reg[i] <= (i == 0) ? v1_reg[H_LAT-1] : v2_reg[i-1];
            end
            for (int i = 0; i < L3; i++) begin
                v3_reg[i] <= (i == 0) ? v2_reg[H_LAT-1] : v3_reg[i-1];
            end
            m_tvalid_reg <= v3_reg[L3-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < H_LAT; i++) begin
                op1_reg[i]    <= (i == 0) ? op_in : op1_reg[i-1];
                a1_reg[i]     <= (i == 0) ? a_in : a1_reg[i-1];
                op2_reg[i]    <= (i == 0) ? op1_reg[H_LAT-1] : op2_reg[i-1];
                a2_reg[i]     <= (i == 0) ? a1_reg[H_LAT-1] : a2_reg[i-1];
                r1_2_reg[i]   <= (i == 0) ? r1 : r1_2_reg[i-1];
                sat1_2_reg[i] <= (i == 0) ? sat1 : sat1_2_reg[i-1];
            end
            for (int i = 0; i < L3; i++) begin
                op3_reg[i] <= (i == 0) ? op2_reg[H_LAT-1] : op3_reg[i-1];
                r3_reg[i]  <= (i == 0) ? misc_r : r3_reg[i-1];
                st3_reg[i] <= (i == 0) ? misc_st : st3_reg[i-1];
            end
            out_op_reg <= op3_reg[L3-1];
            if (op3_reg[L3-1] == OP_NORM) begin
                m_data_reg   <= nq;
                m_status_reg <= nzero ? ST_ZERO : ST_OK;
            end else begin
                m_data_reg   <= r3_reg[L3-1];
                m_status_reg <= st3_reg[L3-1];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

`ifndef NO_ASSERTIONS
    a_zero_norm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_ZERO |-> m_tdata == '0)
        else $error("zero-norm status with nonzero data");

    a_rot_scalar_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_op_reg == OP_ROT |-> m_tdata[DW-1:0] == '0)
        else $error("rotate result has nonzero scalar part");

    a_norm_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_op_reg == OP_NORM |->
            ($signed(m_tdata[2*DW-1:DW]) <= $signed(DW'(1) << FW)) &&
            ($signed(m_tdata[2*DW-1:DW]) >= -$signed(DW'(1) << FW)))
        else $error("normalize component above unit magnitude");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(v3_reg[L3-1]))
        else $error("pipeline advanced during stall");
`endif

endmodule
